@@ sv/tcp_connection_lookup_core_macros.svh @@
// Assertion macros for the TCP connection lookup core checker.
// Depends on nothing; included by the checker file only.
`ifndef TCP_CONNECTION_LOOKUP_CORE_MACROS_SVH
`define TCP_CONNECTION_LOOKUP_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TCL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define TCL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tcl_pkg.sv @@
// Shared types and constants of the TCP connection lookup core.
// Depends on nothing; used by the match unit and the top level.
`timescale 1ns / 1ps

package tcl_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic {
        OP_LOOKUP = 1'b0,
        OP_WRITE  = 1'b1
    } op_e;

    typedef enum logic [1:0] {
        TIER_EXACT           = 2'd0,
        TIER_WILDCARD        = 2'd1,
        TIER_LISTEN_EXACT    = 2'd2,
        TIER_LISTEN_WILDCARD = 2'd3
    } tier_e;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [15:0] local_port_num;
        logic [31:0] remote_addr;
        logic [15:0] remote_port_num;
        logic        is_listening;
    } entry_t;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [15:0] local_port_num;
        logic [31:0] remote_addr;
        logic [15:0] remote_port_num;
    } key_t;

    typedef struct packed {
        logic key_hit;
        logic exact;
        logic wild;
    } match_t;

endpackage

@@ sv/tcl_match.sv @@
// Compare unit shared by both passes of the table scan.
// Depends on tcl_pkg for the entry, key and match types.
`timescale 1ns / 1ps

module tcl_match (
    input  logic           listen_pass,
    input  logic           in_use,
    input  tcl_pkg::entry_t entry,
    input  tcl_pkg::key_t   key,
    output tcl_pkg::match_t hit
);

    logic port_eq;
    logic tuple_eq;

    assign port_eq  = (entry.local_port_num == key.local_port_num);
    assign tuple_eq = port_eq && (entry.remote_addr == key.remote_addr)
                      && (entry.remote_port_num == key.remote_port_num);

    always_comb begin
        if (listen_pass) begin
            hit.key_hit = in_use && entry.is_listening && port_eq;
        end else begin
            hit.key_hit = in_use && tuple_eq;
        end
        hit.exact = (entry.local_addr == key.local_addr);
        hit.wild  = (entry.local_addr == 32'd0);
    end

endmodule

@@ sv/tcp_connection_lookup_core.sv @@
// Top level of the TCP connection lookup core: table, scan sequencer, result register.
// Depends on tcl_pkg and the tcl_match compare unit.
//
//   Channel | Direction | tdata fields (low bit up)                                 | tuser
//   s_      | in        | slot, entry_valid, local_addr, local_port_num,             | op
//           |           | remote_addr, remote_port_num, is_listening, 2 pad bits     |
//   m_      | out       | found, match_slot, match_tier, 1 pad bit                   | none
//
// A write request passes from the idle state through the emit state into the output register.
// A lookup scans one table slot per cycle through a single compare unit, one pass over
// the tuple entries and, on a miss, a second pass over the listening entries; its result
// passes through the emit state. The next request can be taken in the cycle it turns valid.
// A result waits in the output register while the next request is taken in; a result still
// held there stalls the following one in its emit cycle. Reset clears the in-use marks at once.
`timescale 1ns / 1ps

module tcp_connection_lookup_core (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // slot[3:0], entry_valid[4], local_addr[36:5], local_port_num[52:37],
    // remote_addr[84:53], remote_port_num[100:85], is_listening[101], zero[103:102]
    input  logic [103:0] s_tdata,
    // op[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // found[0], match_slot[4:1], match_tier[6:5], zero[7]
    output logic [7:0]   m_tdata
);

    localparam int IW = tcl_pkg::IDX_W;

    typedef enum logic [1:0] {ST_IDLE, ST_PASS1, ST_PASS2, ST_EMIT} state_t;

    state_t              state_reg;
    logic [IW-1:0]       idx_reg;
    logic                have_reg;
    logic [IW-1:0]       keep_reg;
    tcl_pkg::key_t       key_reg;
    logic                res_found_reg;
    logic [3:0]          res_slot_reg;
    logic [1:0]          res_tier_reg;
    logic                m_tvalid_reg;
    logic [7:0]          m_tdata_reg;
    logic                in_use_reg [tcl_pkg::ENTRIES];
    tcl_pkg::entry_t     table_mem [tcl_pkg::ENTRIES];
    tcl_pkg::entry_t     rd_entry_reg;

    logic                s_op;
    logic [3:0]          s_slot;
    logic                s_entry_valid;
    tcl_pkg::entry_t     s_entry;
    logic                accept;
    logic                wr_en;
    logic [IW-1:0]       wr_idx;
    logic [IW-1:0]       rd_addr;
    logic                idx_last;
    logic                scanning;
    tcl_pkg::match_t     hit;

    assign s_op          = s_tuser[0];
    assign s_slot        = s_tdata[3:0];
    assign s_entry_valid = s_tdata[4];
    assign s_entry.local_addr      = s_tdata[36:5];
    assign s_entry.local_port_num  = s_tdata[52:37];
    assign s_entry.remote_addr     = s_tdata[84:53];
    assign s_entry.remote_port_num = s_tdata[100:85];
    assign s_entry.is_listening    = s_tdata[101];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_op == tcl_pkg::OP_WRITE)
                      && (32'(s_slot) < 32'(tcl_pkg::ENTRIES));
    assign wr_idx   = IW'(s_slot);
    assign idx_last = (idx_reg == IW'(tcl_pkg::ENTRIES - 1));
    assign scanning = (state_reg == ST_PASS1) || (state_reg == ST_PASS2);
    assign rd_addr  = (scanning && !idx_last) ? idx_reg + IW'(1) : '0;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    tcl_match u_match (
        .listen_pass (state_reg == ST_PASS2),
        .in_use      (in_use_reg[idx_reg]),
        .entry       (rd_entry_reg),
        .key         (key_reg),
        .hit         (hit)
    );

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_idx] <= s_entry;
        end
        rd_entry_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            have_reg     <= 1'b0;
            for (int i = 0; i < tcl_pkg::ENTRIES; i++) begin
                in_use_reg[i] <= 1'b0;
            end
        end else begin
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        res_found_reg <= 1'b0;
                        res_slot_reg  <= 4'd0;
                        res_tier_reg  <= tcl_pkg::TIER_EXACT;
                        if (s_op == tcl_pkg::OP_WRITE) begin
                            if (wr_en) begin
                                in_use_reg[wr_idx] <= s_entry_valid;
                            end
                            state_reg <= ST_EMIT;
                        end else begin
                            key_reg.local_addr      <= s_entry.local_addr;
                            key_reg.local_port_num  <= s_entry.local_port_num;
                            key_reg.remote_addr     <= s_entry.remote_addr;
                            key_reg.remote_port_num <= s_entry.remote_port_num;
                            idx_reg   <= '0;
                            have_reg  <= 1'b0;
                            state_reg <= ST_PASS1;
                        end
                    end
                end
                ST_PASS1, ST_PASS2: begin
                    if (hit.key_hit && hit.exact) begin
                        res_found_reg <= 1'b1;
                        res_slot_reg  <= 4'(idx_reg);
                        res_tier_reg  <= (state_reg == ST_PASS2) ? tcl_pkg::TIER_LISTEN_EXACT
                                                                 : tcl_pkg::TIER_EXACT;
                        state_reg     <= ST_EMIT;
                    end else begin
                        if (hit.key_hit && hit.wild) begin
                            have_reg <= 1'b1;
                            keep_reg <= idx_reg;
                        end
                        if (idx_last) begin
                            if (have_reg || (hit.key_hit && hit.wild)) begin
                                res_found_reg <= 1'b1;
                                res_slot_reg  <= (hit.key_hit && hit.wild) ? 4'(idx_reg)
                                                                           : 4'(keep_reg);
                                res_tier_reg  <= (state_reg == ST_PASS2)
                                                 ? tcl_pkg::TIER_LISTEN_WILDCARD
                                                 : tcl_pkg::TIER_WILDCARD;
                                state_reg     <= ST_EMIT;
                            end else if (state_reg == ST_PASS1) begin
                                idx_reg   <= '0;
                                state_reg <= ST_PASS2;
                            end else begin
                                state_reg <= ST_EMIT;
                            end
                        end else begin
                            idx_reg <= idx_reg + IW'(1);
                        end
                    end
                end
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tdata_reg  <= {1'b0, res_tier_reg, res_slot_reg, res_found_reg};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/tcl_checker.sv @@
// Port-level checker for the TCP connection lookup core, with its bind statement.
// Depends on tcp_connection_lookup_core_macros.svh and the top level's ports.
`timescale 1ns / 1ps
`include "tcp_connection_lookup_core_macros.svh"

module tcl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata
);

    // A stalled result stays offered.
    `TCL_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A miss reports slot and tier as zero.
    `TCL_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_tvalid && !m_tdata[0], m_tdata[6:1] == 6'd0, "miss with nonzero slot or tier")

    // The sequencer is busy in the cycle after it takes a request.
    `TCL_ASSERT_NEXT(a_busy_after_req, aclk, aresetn, s_tvalid && s_tready, !s_tready, "request taken while busy")

    // Reset clears the valid flag of the output register.
    `TCL_ASSERT_NEXT_ALWAYS(a_reset_clear, aclk, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind tcp_connection_lookup_core tcl_checker u_tcl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
